// ----- hw/rtl/thermistor_temperature_linearizer_macros.svh -----
// ----------------------------------------------------------------------------
// Thermistor linearizer assertion macros
// Concurrent checks clocked on clk and switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_TEMPERATURE_LINEARIZER_MACROS_SVH
`define THERMISTOR_TEMPERATURE_LINEARIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define TLIN_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define TLIN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/tlin_pkg.sv -----
// ----------------------------------------------------------------------------
// Thermistor linearizer package
// Shared codes, constants, controller states and control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package tlin_pkg;

	// Result status codes
	localparam logic [1:0] STS_VALID   = 2'd0;
	localparam logic [1:0] STS_ADC_ERR = 2'd1;
	localparam logic [1:0] STS_RANGE   = 2'd2;

	// Configuration register indexes
	localparam logic [2:0] REG_MIN_MV  = 3'd0;
	localparam logic [2:0] REG_MAX_MV  = 3'd1;
	localparam logic [2:0] REG_PULLUP  = 3'd2;
	localparam logic [2:0] REG_SUPPLY  = 3'd3;
	localparam logic [2:0] REG_COEF_A  = 3'd4;
	localparam logic [2:0] REG_COEF_B  = 3'd5;
	localparam logic [2:0] REG_COEF_C  = 3'd6;

	// Register reset values
	localparam logic [12:0] RST_MIN_MV = 13'd100;
	localparam logic [12:0] RST_MAX_MV = 13'd3200;
	localparam logic [19:0] RST_PULLUP = 20'd10000;
	localparam logic [12:0] RST_SUPPLY = 13'd3300;
	localparam logic signed [48:0] RST_COEF_A = -49'sd256802152294;
	localparam logic signed [48:0] RST_COEF_B = 49'sd147206537757;
	localparam logic signed [48:0] RST_COEF_C = -49'sd198317138;

	// Arithmetic constants
	localparam logic [30:0] LN2_Q30     = 31'd744261118;
	localparam logic [63:0] TERM_LIM    = 64'h2000_0000_0000_0000;
	localparam logic [54:0] HUNDRED_Q48 = 55'd100 << 48;
	localparam logic [15:0] KELVIN_C100 = 16'd27315;
	localparam logic [15:0] MAG_CAP     = 16'd51200;
	localparam logic [9:0]  RECIP_100   = 10'd656;
	localparam logic [9:0]  TEMP_MAX    = 10'd511;
	localparam logic [5:0]  DIV_R_ITERS = 6'd41;
	localparam logic [5:0]  DIV_T_ITERS = 6'd55;
	localparam logic [5:0]  LOG_TOP_EXP = 6'd40;
	localparam logic [4:0]  SQR_STEPS   = 5'd23;
	localparam logic [4:0]  MUL_STEPS   = 5'd3;

	typedef enum logic [3:0] {
		ST_IDLE, ST_DIV_R, ST_NORM, ST_SQR, ST_LN, ST_MSTART, ST_MSTEP, ST_MWRITE,
		ST_SUM, ST_DCHK, ST_DIV_T, ST_CEL1, ST_CEL2, ST_FIN
	} state_t;

	// Product terms worked out on the shared multiplier
	typedef enum logic [1:0] {MOP_L2, MOP_L3, MOP_TB, MOP_TC} mop_t;

	// How an item ends
	typedef enum logic [1:0] {FIN_HOLD, FIN_RANGE, FIN_DZERO, FIN_CEL} fin_t;

	typedef struct packed {
		logic load;
		logic norm_load;
		logic norm_step;
		logic sq_load;
		logic sq_step;
		logic ln_calc;
		logic mul_start;
		mop_t mul_op;
		logic mul_step;
		logic mul_write;
		logic sum;
		logic div_t_start;
		logic cel1;
		logic cel2;
		logic fin;
		fin_t fin_kind;
	} cmd_t;

	typedef struct packed {
		logic bad;
		logic rq_zero;
		logic div_busy;
		logic norm_done;
		logic d_zero;
	} sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tlin_if.sv -----
// ----------------------------------------------------------------------------
// Thermistor linearizer channels
// Valid/ready interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tlin_sample_if;
	logic        valid;
	logic        ready;
	logic [12:0] sample_mv;
	logic        adc_ok;
	modport source (output valid, sample_mv, adc_ok, input ready);
	modport sink (input valid, sample_mv, adc_ok, output ready);
endinterface

interface tlin_result_if;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic signed [9:0] temperature;
	modport source (output valid, status, temperature, input ready);
	modport sink (input valid, status, temperature, output ready);
endinterface

interface tlin_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [48:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tlin_div.sv -----
// ----------------------------------------------------------------------------
// Thermistor linearizer divider
// Restoring divider, one quotient bit per cycle, iteration count per start.
// ----------------------------------------------------------------------------
`default_nettype none

module tlin_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [54:0] dividend,
	input  wire logic [63:0] divisor,
	input  wire logic [5:0]  iters,
	output logic             busy,
	output logic [54:0]      quot,
	output logic             rem_nz
);

	logic [63:0] rem_q;
	logic [54:0] dq_q;
	logic [63:0] dvs_q;
	logic [5:0]  cnt_q;
	logic [64:0] trial;
	logic        fits;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, dq_q[54]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Iteration counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= iters;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	// Partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != 6'd0) begin
			rem_q <= fits ? 64'(trial - {1'b0, dvs_q}) : trial[63:0];
			dq_q  <= {dq_q[53:0], fits};
		end
	end

	assign busy   = cnt_q != 6'd0;
	assign quot   = dq_q;
	assign rem_nz = |rem_q;

endmodule

`default_nettype wire

// ----- hw/rtl/tlin_ctrl.sv -----
// ----------------------------------------------------------------------------
// Thermistor linearizer controller
// Sequences one sample through division, logarithm, products and reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none

module tlin_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire logic         out_ready,
	input  wire tlin_pkg::sts_t sts,
	output tlin_pkg::cmd_t    cmd
);

	tlin_pkg::state_t state_q, state_d;
	logic [4:0]       cnt_q, cnt_d;
	tlin_pkg::mop_t   mop_q, mop_d;
	tlin_pkg::fin_t   fin_q, fin_d;
	logic             out_valid_q;

	// State and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tlin_pkg::ST_IDLE;
			cnt_q   <= '0;
			mop_q   <= tlin_pkg::MOP_L2;
			fin_q   <= tlin_pkg::FIN_HOLD;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			mop_q   <= mop_d;
			fin_q   <= fin_d;
		end
	end

	// Result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign in_ready  = state_q == tlin_pkg::ST_IDLE;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		mop_d   = mop_q;
		fin_d   = fin_q;
		cmd     = '0;
		cmd.mul_op   = mop_q;
		cmd.fin_kind = fin_q;
		case (state_q)
			tlin_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = tlin_pkg::ST_DIV_R;
				end
			end
			tlin_pkg::ST_DIV_R: begin
				if (sts.bad) begin
					fin_d   = tlin_pkg::FIN_HOLD;
					state_d = tlin_pkg::ST_FIN;
				end else if (!sts.div_busy) begin
					if (sts.rq_zero) begin
						fin_d   = tlin_pkg::FIN_RANGE;
						state_d = tlin_pkg::ST_FIN;
					end else begin
						cmd.norm_load = 1'b1;
						state_d       = tlin_pkg::ST_NORM;
					end
				end
			end
			tlin_pkg::ST_NORM: begin
				if (sts.norm_done) begin
					cmd.sq_load = 1'b1;
					cnt_d       = tlin_pkg::SQR_STEPS;
					state_d     = tlin_pkg::ST_SQR;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			tlin_pkg::ST_SQR: begin
				cmd.sq_step = 1'b1;
				if (cnt_q == 5'd0) begin
					state_d = tlin_pkg::ST_LN;
				end else begin
					cnt_d = cnt_q - 5'd1;
				end
			end
			tlin_pkg::ST_LN: begin
				cmd.ln_calc = 1'b1;
				mop_d       = tlin_pkg::MOP_L2;
				state_d     = tlin_pkg::ST_MSTART;
			end
			tlin_pkg::ST_MSTART: begin
				cmd.mul_start = 1'b1;
				cnt_d         = tlin_pkg::MUL_STEPS;
				state_d       = tlin_pkg::ST_MSTEP;
			end
			tlin_pkg::ST_MSTEP: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == 5'd0) begin
					state_d = tlin_pkg::ST_MWRITE;
				end else begin
					cnt_d = cnt_q - 5'd1;
				end
			end
			tlin_pkg::ST_MWRITE: begin
				cmd.mul_write = 1'b1;
				state_d       = tlin_pkg::ST_MSTART;
				case (mop_q)
					tlin_pkg::MOP_L2: mop_d = tlin_pkg::MOP_L3;
					tlin_pkg::MOP_L3: mop_d = tlin_pkg::MOP_TB;
					tlin_pkg::MOP_TB: mop_d = tlin_pkg::MOP_TC;
					default: state_d = tlin_pkg::ST_SUM;
				endcase
			end
			tlin_pkg::ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = tlin_pkg::ST_DCHK;
			end
			tlin_pkg::ST_DCHK: begin
				if (sts.d_zero) begin
					fin_d   = tlin_pkg::FIN_DZERO;
					state_d = tlin_pkg::ST_FIN;
				end else begin
					cmd.div_t_start = 1'b1;
					state_d         = tlin_pkg::ST_DIV_T;
				end
			end
			tlin_pkg::ST_DIV_T: begin
				if (!sts.div_busy) begin
					state_d = tlin_pkg::ST_CEL1;
				end
			end
			tlin_pkg::ST_CEL1: begin
				cmd.cel1 = 1'b1;
				state_d  = tlin_pkg::ST_CEL2;
			end
			tlin_pkg::ST_CEL2: begin
				cmd.cel2 = 1'b1;
				fin_d    = tlin_pkg::FIN_CEL;
				state_d  = tlin_pkg::ST_FIN;
			end
			tlin_pkg::ST_FIN: begin
				// Hand over once the result register is free or emptying
				if (!out_valid_q || out_ready) begin
					cmd.fin = 1'b1;
					state_d = tlin_pkg::ST_IDLE;
				end
			end
			default: state_d = tlin_pkg::ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/tlin_dp.sv -----
// ----------------------------------------------------------------------------
// Thermistor linearizer datapath
// Registers, divider, log unit, shared multiplier and Celsius conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module tlin_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tlin_pkg::cmd_t cmd,
	output tlin_pkg::sts_t      sts,
	input  wire logic [12:0]    sample_mv,
	input  wire logic           adc_ok,
	input  wire logic           cfg_we,
	input  wire logic [2:0]     cfg_index,
	input  wire logic [48:0]    cfg_data,
	output logic [1:0]          res_status,
	output logic signed [9:0]   res_temperature
);

	// Configuration
	logic [12:0]        min_mv_q, max_mv_q, supply_mv_q;
	logic [19:0]        pullup_q;
	logic signed [48:0] coef_a_q, coef_b_q, coef_c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_mv_q    <= tlin_pkg::RST_MIN_MV;
			max_mv_q    <= tlin_pkg::RST_MAX_MV;
			pullup_q    <= tlin_pkg::RST_PULLUP;
			supply_mv_q <= tlin_pkg::RST_SUPPLY;
			coef_a_q    <= tlin_pkg::RST_COEF_A;
			coef_b_q    <= tlin_pkg::RST_COEF_B;
			coef_c_q    <= tlin_pkg::RST_COEF_C;
		end else if (cfg_we) begin
			case (cfg_index)
				tlin_pkg::REG_MIN_MV: min_mv_q    <= cfg_data[12:0];
				tlin_pkg::REG_MAX_MV: max_mv_q    <= cfg_data[12:0];
				tlin_pkg::REG_PULLUP: pullup_q    <= cfg_data[19:0];
				tlin_pkg::REG_SUPPLY: supply_mv_q <= cfg_data[12:0];
				tlin_pkg::REG_COEF_A: coef_a_q    <= cfg_data;
				tlin_pkg::REG_COEF_B: coef_b_q    <= cfg_data;
				tlin_pkg::REG_COEF_C: coef_c_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sample check
	logic [1:0]  in_status, status_q;
	logic [32:0] vp;

	always_comb begin
		if (!adc_ok) begin
			in_status = tlin_pkg::STS_ADC_ERR;
		end else if (sample_mv < min_mv_q || sample_mv > max_mv_q ||
				sample_mv >= supply_mv_q) begin
			in_status = tlin_pkg::STS_RANGE;
		end else begin
			in_status = tlin_pkg::STS_VALID;
		end
	end

	assign vp = 33'(sample_mv) * 33'(pullup_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q <= in_status;
		end
	end

	// Shared divider: resistance first, then the reciprocal
	logic               div_start, div_busy, div_rem_nz;
	logic [54:0]        div_dividend, div_quot;
	logic [63:0]        div_divisor;
	logic [5:0]         div_iters;
	logic signed [63:0] d_q;
	logic [63:0]        d_mag;

	assign d_mag        = d_q[63] ? 64'(-d_q) : d_q;
	assign div_start    = cmd.load | cmd.div_t_start;
	assign div_dividend = cmd.load ? {vp, 22'd0} : tlin_pkg::HUNDRED_Q48;
	assign div_divisor  = cmd.load ? 64'(13'(supply_mv_q - sample_mv)) : d_mag;
	assign div_iters    = cmd.load ? tlin_pkg::DIV_R_ITERS : tlin_pkg::DIV_T_ITERS;

	tlin_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.iters    (div_iters),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem_nz   (div_rem_nz)
	);

	// Normalise the resistance, leading one to the top bit
	logic [40:0] x_q;
	logic [5:0]  e_q;

	always_ff @(posedge clk) begin
		if (cmd.norm_load) begin
			x_q <= div_quot[40:0];
			e_q <= tlin_pkg::LOG_TOP_EXP;
		end else if (cmd.norm_step) begin
			if (x_q[40:33] == 8'd0) begin
				x_q <= {x_q[32:0], 8'd0};
				e_q <= e_q - 6'd8;
			end else if (!x_q[40]) begin
				x_q <= {x_q[39:0], 1'b0};
				e_q <= e_q - 6'd1;
			end
		end
	end

	// Log2 fraction by repeated squaring, one bit per cycle
	logic [30:0] y_q;
	logic [23:0] frac_q;
	logic [61:0] sq;
	logic [31:0] yn;

	assign sq = 62'(y_q) * 62'(y_q);
	assign yn = sq[61:30];

	always_ff @(posedge clk) begin
		if (cmd.sq_load) begin
			y_q    <= x_q[40:10];
			frac_q <= '0;
		end else if (cmd.sq_step) begin
			if (yn[31]) begin
				y_q    <= yn[31:1];
				frac_q <= {frac_q[22:0], 1'b1};
			end else begin
				y_q    <= yn[30:0];
				frac_q <= {frac_q[22:0], 1'b0};
			end
		end
	end

	// Natural log: scale log2 by ln 2, floor
	logic [6:0]         e_m8;
	logic signed [30:0] log2_v;
	logic signed [31:0] ln2_s;
	logic signed [62:0] lnp;
	logic signed [31:0] l_q;

	assign e_m8   = 7'({1'b0, e_q}) - 7'd8;
	assign log2_v = $signed({e_m8, frac_q});
	assign ln2_s  = $signed(32'(tlin_pkg::LN2_Q30));
	assign lnp    = 63'(log2_v) * 63'(ln2_s);

	always_ff @(posedge clk) begin
		if (cmd.ln_calc) begin
			l_q <= lnp[61:30];
		end
	end

	// Shared multiplier: sign-magnitude, 16 multiplier bits per cycle
	logic signed [63:0] l2_q, l3_q, tb_q, tc_q;
	logic signed [63:0] ma, mb;
	logic [63:0]        ua_q, ub_q;
	logic               neg_q;
	logic [127:0]       acc_q;
	tlin_pkg::mop_t     mop_q;
	logic [79:0]        pp;
	logic               qhi_nz, rem_nz, over;
	logic [63:0]        qlo, qadj, mag;
	logic signed [63:0] mres;

	always_comb begin
		case (cmd.mul_op)
			tlin_pkg::MOP_L2: begin
				ma = 64'(l_q);
				mb = 64'(l_q);
			end
			tlin_pkg::MOP_L3: begin
				ma = l2_q;
				mb = 64'(l_q);
			end
			tlin_pkg::MOP_TB: begin
				ma = 64'(coef_b_q);
				mb = 64'(l_q);
			end
			default: begin
				ma = 64'(coef_c_q);
				mb = l3_q;
			end
		endcase
	end

	assign pp = 80'(ua_q) * 80'(ub_q[63:48]);

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			ua_q  <= ma[63] ? 64'(-ma) : ma;
			ub_q  <= mb[63] ? 64'(-mb) : mb;
			neg_q <= ma[63] ^ mb[63];
			acc_q <= '0;
			mop_q <= cmd.mul_op;
		end else if (cmd.mul_step) begin
			acc_q <= {acc_q[111:0], 16'd0} + 128'(pp);
			ub_q  <= {ub_q[47:0], 16'd0};
		end
	end

	// Floor of product over 2^24, magnitude saturated
	assign qhi_nz = |acc_q[127:88];
	assign qlo    = acc_q[87:24];
	assign rem_nz = |acc_q[23:0];
	assign over   = qhi_nz || qlo > tlin_pkg::TERM_LIM;
	assign qadj   = qlo + 64'(neg_q && rem_nz);
	assign mag    = (over || qadj > tlin_pkg::TERM_LIM) ? tlin_pkg::TERM_LIM : qadj;
	assign mres   = neg_q ? $signed(64'(-mag)) : $signed(mag);

	always_ff @(posedge clk) begin
		if (cmd.mul_write) begin
			case (mop_q)
				tlin_pkg::MOP_L2: l2_q <= mres;
				tlin_pkg::MOP_L3: l3_q <= mres;
				tlin_pkg::MOP_TB: tb_q <= mres;
				default: tc_q <= mres;
			endcase
		end
	end

	// Denominator
	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			d_q <= 64'(coef_a_q) + tb_q + tc_q;
		end
	end

	// Celsius: offset, exact truncation, divide by 100 via reciprocal
	logic signed [57:0] qv, nv;
	logic [57:0]        magv;
	logic [15:0]        magc;
	logic [25:0]        qep;
	logic [15:0]        magc_q;
	logic [9:0]         qe_q, tq, tsat;
	logic               tneg_q;
	logic [16:0]        qe100;
	logic signed [9:0]  cel_q;

	always_comb begin
		if (d_q[63]) begin
			qv = -$signed(58'(div_quot) + 58'(div_rem_nz));
		end else begin
			qv = $signed(58'(div_quot));
		end
		nv = qv - $signed(58'(tlin_pkg::KELVIN_C100));
		if (nv[57]) begin
			magv = 58'(-(nv + $signed(58'(div_rem_nz))));
		end else begin
			magv = nv;
		end
		magc = (magv >= 58'(tlin_pkg::MAG_CAP)) ? tlin_pkg::MAG_CAP : magv[15:0];
	end

	assign qep   = 26'(magc) * 26'(tlin_pkg::RECIP_100);
	assign qe100 = 17'(qe_q) * 17'd100;
	assign tq    = (17'(magc_q) < qe100) ? qe_q - 10'd1 : qe_q;
	assign tsat  = (tq > tlin_pkg::TEMP_MAX) ? tlin_pkg::TEMP_MAX : tq;

	always_ff @(posedge clk) begin
		if (cmd.cel1) begin
			magc_q <= magc;
			qe_q   <= qep[25:16];
			tneg_q <= nv[57];
		end
		if (cmd.cel2) begin
			cel_q <= tneg_q ? $signed(-tsat) : $signed(tsat);
		end
	end

	// Held temperature
	logic signed [9:0] held_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd.fin) begin
			if (cmd.fin_kind == tlin_pkg::FIN_DZERO) begin
				held_q <= $signed(tlin_pkg::TEMP_MAX);
			end else if (cmd.fin_kind == tlin_pkg::FIN_CEL) begin
				held_q <= cel_q;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			case (cmd.fin_kind)
				tlin_pkg::FIN_HOLD: begin
					res_status      <= status_q;
					res_temperature <= held_q;
				end
				tlin_pkg::FIN_RANGE: begin
					res_status      <= tlin_pkg::STS_RANGE;
					res_temperature <= held_q;
				end
				tlin_pkg::FIN_DZERO: begin
					res_status      <= tlin_pkg::STS_VALID;
					res_temperature <= $signed(tlin_pkg::TEMP_MAX);
				end
				default: begin
					res_status      <= tlin_pkg::STS_VALID;
					res_temperature <= cel_q;
				end
			endcase
		end
	end

	// Status to the controller
	assign sts.bad       = status_q != tlin_pkg::STS_VALID;
	assign sts.rq_zero   = div_quot[40:0] == 41'd0;
	assign sts.div_busy  = div_busy;
	assign sts.norm_done = x_q[40];
	assign sts.d_zero    = d_q == 64'sd0;

endmodule

`default_nettype wire

// ----- hw/rtl/thermistor_temperature_linearizer.sv -----
// ----------------------------------------------------------------------------
// Thermistor temperature linearizer
// Divider voltage to whole degrees Celsius by the Steinhart-Hart equation.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one divider voltage in mV and an ADC success flag per transfer.
//   result : one status and temperature per sample, in sample order.
//   cfg    : register writes (index 0..6), always ready; write only when idle.
// Sequence: a failed or out-of-window sample goes straight to the result. A good
//   sample runs the resistance division, normalisation, 24 log squaring steps,
//   four products on the shared 64x16 multiplier and the reciprocal division.
// Throughput: one sample at a time; the next sample is taken as soon as the
//   previous one sits in the result register.
// Stall: a held-off result stays in the result register; a following result
//   waits inside the block until that register empties.
// Reset: configuration registers return to their defaults and the held temperature to 0.
// ----------------------------------------------------------------------------
`default_nettype none

module thermistor_temperature_linearizer (
	input  wire logic     clk,
	input  wire logic     arst_n,
	tlin_sample_if.sink   sample,
	tlin_result_if.source result,
	tlin_cfg_if.sink      cfg
);

	tlin_pkg::cmd_t cmd;
	tlin_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	tlin_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tlin_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.sample_mv       (sample.sample_mv),
		.adc_ok          (sample.adc_ok),
		.cfg_we          (cfg.valid),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.res_status      (result.status),
		.res_temperature (result.temperature)
	);

`include "thermistor_temperature_linearizer_macros.svh"

	`TLIN_ASSERT_NEXT(a_busy_after_transfer, sample.valid && sample.ready, !sample.ready, "sample taken while busy")
	`TLIN_ASSERT_SAME(a_temp_saturated, result.valid, result.temperature != -10'sd512, "temperature out of range")
	`TLIN_ASSERT_SAME(a_result_from_work, $rose(result.valid), !$past(sample.ready), "result without work")

endmodule

`default_nettype wire
